// ----- rtl/top_k_heavy_hitter_table_macros.svh -----
// Assertion helpers shared by the table modules.
`ifndef TOP_K_HEAVY_HITTER_TABLE_MACROS_SVH
`define TOP_K_HEAVY_HITTER_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define THH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define THH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/thh_pkg.sv -----
package thh_pkg;

  localparam int NUM_SLOTS_DEFAULT = 16;

  localparam int CMD_W   = 2;
  localparam int KEY_W   = 32;
  localparam int COUNT_W = 32;
  localparam int ACT_W   = 2;
  localparam int SLOT_W  = 4;
  localparam int EVENT_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [ACT_W-1:0] ACT_UPDATED  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REPLACED = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REJECTED = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEARED  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic take;    // input may be accepted
    logic scan;    // issue the next slot read
    logic commit;  // write back and load the result register
  } thh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic accepted;  // word taken this cycle
    logic lookup;    // accepted word needs a slot scan
    logic last;      // read of the final slot issued this cycle
    logic out_free;  // result register can be loaded
  } thh_sts_t;

endpackage

// ----- rtl/thh_item_if.sv -----
interface thh_item_if;
  import thh_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [KEY_W-1:0]   key;
  logic [COUNT_W-1:0] estimate;

  modport source (output valid, output command, output key, output estimate, input ready);
  modport sink   (input valid, input command, input key, input estimate, output ready);
endinterface

// ----- rtl/thh_result_if.sv -----
interface thh_result_if;
  import thh_pkg::*;

  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [SLOT_W-1:0]  slot;
  logic [EVENT_W-1:0] events_seen;

  modport source (output valid, output action, output slot, output events_seen, input ready);
  modport sink   (input valid, input action, input slot, input events_seen, output ready);
endinterface

// ----- rtl/thh_ctrl.sv -----
`include "top_k_heavy_hitter_table_macros.svh"

module thh_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  thh_pkg::thh_sts_t sts,
  output thh_pkg::thh_cmd_t cmd
);
  import thh_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_LAST   = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (sts.accepted) begin
          state_next = sts.lookup ? ST_SCAN : ST_COMMIT;
        end
      end
      ST_SCAN: begin
        if (sts.last) begin
          state_next = ST_LAST;
        end
      end
      // data of the final slot is compared here
      ST_LAST: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd.take   = (state == ST_IDLE);
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.commit = (state == ST_COMMIT);

  `THH_ASSERT_NEXT(a_direct_commit, sts.accepted && !sts.lookup, state == ST_COMMIT, "no commit after non-lookup word")
  `THH_ASSERT_NEXT(a_scan_end, (state == ST_SCAN) && sts.last, state == ST_LAST, "scan did not end after final slot")
  `THH_ASSERT_NOW(a_accept_idle, sts.accepted, state == ST_IDLE, "word accepted while busy")

endmodule

// ----- rtl/thh_datapath.sv -----
`include "top_k_heavy_hitter_table_macros.svh"

module thh_datapath #(
  parameter int NUM_SLOTS = thh_pkg::NUM_SLOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  thh_item_if.sink          items,
  thh_result_if.source      results,
  input  thh_pkg::thh_cmd_t cmd,
  output thh_pkg::thh_sts_t sts
);
  import thh_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  // slot memory, single write and single registered read port
  logic [KEY_W-1:0]   mem_key   [NUM_SLOTS];
  logic [COUNT_W-1:0] mem_count [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_valid;

  logic [CMD_W-1:0]   item_cmd;
  logic [KEY_W-1:0]   item_key;
  logic [COUNT_W-1:0] item_est;

  logic [IDX_W-1:0]   cnt;
  logic               d_vld;
  logic [IDX_W-1:0]   d_idx;
  logic [KEY_W-1:0]   rd_key;
  logic [COUNT_W-1:0] rd_count;
  logic               rd_ok;
  logic [KEY_W-1:0]   eff_key;
  logic [COUNT_W-1:0] eff_count;

  logic               found;
  logic [IDX_W-1:0]   found_at;
  logic [COUNT_W-1:0] low;
  logic [IDX_W-1:0]   low_at;

  logic [EVENT_W-1:0] event_total;

  logic               out_valid;
  logic [ACT_W-1:0]   out_action;
  logic [SLOT_W-1:0]  out_slot;
  logic [EVENT_W-1:0] out_events;

  logic               accept;
  logic               commit;
  logic [ACT_W-1:0]   act_next;
  logic [IDX_W-1:0]   where_next;
  logic [EVENT_W-1:0] events_next;
  logic               wr_en;
  logic               clear_all;
  logic [IDX_W+SLOT_W-1:0] where_ext;

  assign items.ready = cmd.take;
  assign accept      = items.valid && cmd.take;
  assign commit      = cmd.commit && sts.out_free;

  assign sts.accepted = accept;
  assign sts.lookup   = (items.command == CMD_ADD) || (items.command == CMD_QUERY);
  assign sts.last     = cmd.scan && (cnt == LAST_IDX);
  assign sts.out_free = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      item_cmd <= items.command;
      item_key <= items.key;
      item_est <= items.estimate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      d_vld <= 1'b0;
    end else begin
      d_vld <= cmd.scan;
      if (accept) begin
        cnt <= '0;
      end else if (cmd.scan) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_idx    <= cnt;
    rd_key   <= mem_key[cnt];
    rd_count <= mem_count[cnt];
    rd_ok    <= slot_valid[cnt];
  end

  // a slot never written since reset or clear holds key 0, count 0
  assign eff_key   = rd_ok ? rd_key : '0;
  assign eff_count = rd_ok ? rd_count : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (accept) begin
      found <= 1'b0;
    end else if (d_vld && !found && (eff_key == item_key)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_at <= '0;
      low      <= COUNT_MAX;
      low_at   <= '0;
    end else if (d_vld && !found) begin
      if (eff_key == item_key) begin
        found_at <= d_idx;
      end else if (eff_count < low) begin
        low    <= eff_count;
        low_at <= d_idx;
      end
    end
  end

  always_comb begin
    act_next    = ACT_REJECTED;
    where_next  = '0;
    events_next = event_total;
    wr_en       = 1'b0;
    clear_all   = 1'b0;
    unique case (item_cmd)
      CMD_ADD, CMD_QUERY: begin
        if (item_cmd == CMD_ADD) begin
          events_next = event_total + 1'b1;
        end
        if (found) begin
          act_next   = ACT_UPDATED;
          where_next = found_at;
          wr_en      = 1'b1;
        end else if (item_est > low) begin
          act_next   = ACT_REPLACED;
          where_next = low_at;
          wr_en      = 1'b1;
        end
      end
      CMD_CLEAR: begin
        act_next    = ACT_CLEARED;
        events_next = '0;
        clear_all   = 1'b1;
      end
      default: begin
        act_next = ACT_REJECTED;
      end
    endcase
  end

  assign where_ext = {{SLOT_W{1'b0}}, where_next};

  always_ff @(posedge clk) begin
    if (commit && wr_en) begin
      mem_key[where_next]   <= item_key;
      mem_count[where_next] <= item_est;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid  <= '0;
      event_total <= '0;
    end else if (commit) begin
      event_total <= events_next;
      if (clear_all) begin
        slot_valid <= '0;
      end else if (wr_en) begin
        slot_valid[where_next] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_action <= act_next;
      out_slot   <= where_ext[SLOT_W-1:0];
      out_events <= events_next;
    end
  end

  assign results.valid       = out_valid;
  assign results.action      = out_action;
  assign results.slot        = out_slot;
  assign results.events_seen = out_events;

  `THH_ASSERT_NEXT(a_commit_loads, commit, out_valid, "result register not loaded on commit")
  `THH_ASSERT_NEXT(a_clear_wipes, commit && clear_all, (event_total == '0) && (slot_valid == '0), "clear left state behind")
  `THH_ASSERT_NEXT(a_scan_restart, accept, !found && (cnt == '0), "scan state not reset on accept")

endmodule

// ----- rtl/top_k_heavy_hitter_table.sv -----
// Top-k heavy hitter table. Each word on items carries a command, a key and
// the sketch's count estimate; exactly one word per item comes back on
// results. Add and query scan the NUM_SLOTS slots through the single read
// port of the slot memory, one slot a cycle; such an item passes through
// accept, scan, final compare and write-back; write-back waits while the
// output register is full. Clear and the unused command skip the scan.
// One item is in work at a time; a new word is accepted while a
// finished result still waits in the output register. Per-slot valid bits
// make reset and clear take effect at once, with no clearing pass.
module top_k_heavy_hitter_table #(
  parameter int NUM_SLOTS = thh_pkg::NUM_SLOTS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  thh_item_if.sink     items,
  thh_result_if.source results
);
  import thh_pkg::*;

  thh_cmd_t cmd;
  thh_sts_t sts;

  thh_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  thh_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule
